@@ hdl/dwpn_pkg.sv @@
// Shared types, event and reason codes, and page helpers for the display
// wake and page navigation policy. No dependencies.
package dwpn_pkg;

  localparam int unsigned TimeW = 64;
  localparam int unsigned DurW  = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned LimW  = 15;

  typedef logic [3:0]       func_t;
  typedef logic [3:0]       reason_t;
  typedef logic [1:0]       page_t;
  typedef logic [1:0]       cfg_idx_t;
  typedef logic [TimeW-1:0] time_t;
  typedef logic [DurW-1:0]  dur_t;

  // Event codes.
  localparam func_t FUNC_ACTIVITY = 4'd0;
  localparam func_t FUNC_IDLE_CHK = 4'd1;
  localparam func_t FUNC_TOUCH    = 4'd2;
  localparam func_t FUNC_POWER    = 4'd3;
  localparam func_t FUNC_SW_LEFT  = 4'd4;
  localparam func_t FUNC_SW_RIGHT = 4'd5;
  localparam func_t FUNC_SW_DOWN  = 4'd6;
  localparam func_t FUNC_SW_UP    = 4'd7;
  localparam func_t FUNC_RESTART  = 4'd8;

  // Reason codes.
  localparam reason_t RSN_IGNORED     = 4'd0;
  localparam reason_t RSN_ACTIVITY    = 4'd1;
  localparam reason_t RSN_IDLE_OFF    = 4'd2;
  localparam reason_t RSN_TOUCH_WAKE  = 4'd3;
  localparam reason_t RSN_GLITCH      = 4'd4;
  localparam reason_t RSN_LONG        = 4'd5;
  localparam reason_t RSN_KEY_WAKE    = 4'd6;
  localparam reason_t RSN_KEY_CLOSE   = 4'd7;
  localparam reason_t RSN_KEY_PAGE    = 4'd8;
  localparam reason_t RSN_CLOSE_SET   = 4'd9;
  localparam reason_t RSN_OPEN_SET    = 4'd10;
  localparam reason_t RSN_SWIPE_PAGE  = 4'd11;
  localparam reason_t RSN_RESTARTED   = 4'd12;

  // Pages.
  localparam page_t PAGE_MAIN  = 2'd0;
  localparam page_t PAGE_TEXT  = 2'd1;
  localparam page_t PAGE_STATS = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_IDLE_TIMEOUT = 2'd0;
  localparam cfg_idx_t CFG_PRESS_MIN    = 2'd1;
  localparam cfg_idx_t CFG_PRESS_MAX    = 2'd2;

  localparam logic [7:0]      IDLE_SEC_RST  = 8'd15;
  localparam logic [CfgW-1:0] PRESS_MIN_RST = 16'd50;
  localparam logic [CfgW-1:0] PRESS_MAX_RST = 16'd1000;

  typedef struct packed {
    logic [7:0]      idle_sec;
    logic [CfgW-1:0] press_min;
    logic [CfgW-1:0] press_max;
  } cfg_t;

  typedef struct packed {
    page_t page;
    logic  settings;
    logic  screen;
    time_t last_ms;
  } state_t;

  typedef struct packed {
    logic    changed;
    page_t   page;
    logic    settings;
    logic    screen;
    logic    wake;
    logic    blank;
    logic    rst_idle;
    reason_t reason;
  } dec_t;

  function automatic page_t page_next(input page_t p);
    case (p)
      PAGE_MAIN: page_next = PAGE_TEXT;
      PAGE_TEXT: page_next = PAGE_STATS;
      default:   page_next = PAGE_MAIN;
    endcase
  endfunction

  function automatic page_t page_prev(input page_t p);
    case (p)
      PAGE_MAIN:  page_prev = PAGE_STATS;
      PAGE_TEXT:  page_prev = PAGE_MAIN;
      PAGE_STATS: page_prev = PAGE_TEXT;
      default:    page_prev = PAGE_MAIN;
    endcase
  endfunction

  // Only 5, 15 and 30 seconds are honored; anything else means 15.
  function automatic logic [LimW-1:0] timeout_ms(input logic [7:0] sec);
    case (sec)
      8'd5:    timeout_ms = 15'd5000;
      8'd30:   timeout_ms = 15'd30000;
      default: timeout_ms = 15'd15000;
    endcase
  endfunction

endpackage

@@ hdl/display_wake_and_page_nav_policy.sv @@
// Top level of the display wake and page navigation policy: input register,
// policy state, result register. Depends on dwpn_pkg, dwpn_cfg_regs, dwpn_decide.
//
// Usage:
//   Events arrive on the in_ channel (func, now_ms, press_len_ms) and each one
//   yields exactly one decision beat on the out_ channel. Both channels use
//   valid/stall; a beat moves on a rising edge with valid high, stall low.
//   An event is captured in the input register, then evaluated against the
//   current state while the state and the result register are updated
//   together. out_valid rises once the input register's event has moved into
//   the result register, which waits while the receiver stalls a held beat.
//   Throughput is one event per cycle while the receiver does not stall: the
//   update of the page, flags and activity time is the loop that sets that rate.
//   When the receiver stalls, the result register holds its beat and the input
//   register fills; in_stall rises only once both are occupied. The cfg_ port
//   writes the idle timeout (index 0) and short-press limits (indexes 1, 2); the
//   user must write only while no event is in flight; the block does not check.
//   Synchronous reset (rst_n low) empties both registers, returns the page
//   to main, closes settings, turns the screen on, clears the activity time
//   and loads the register defaults.
module display_wake_and_page_nav_policy (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dwpn_pkg::func_t     in_func,
  input  dwpn_pkg::time_t     in_now_ms,
  input  dwpn_pkg::dur_t      in_press_len_ms,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_changed,
  output dwpn_pkg::page_t     out_active_page,
  output logic                out_settings_open,
  output logic                out_screen_on,
  output logic                out_wake_display,
  output logic                out_blank_display,
  output logic                out_reset_idle,
  output dwpn_pkg::reason_t   out_reason,
  input  logic                cfg_wr_en,
  input  dwpn_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import dwpn_pkg::*;

  cfg_t   cfg;
  state_t st_r;
  state_t st_nxt;
  dec_t   dec;
  dec_t   dec_r;

  logic   q_vld_r;
  func_t  q_func_r;
  time_t  q_now_r;
  dur_t   q_dur_r;
  logic   out_vld_r;

  logic   out_free;
  logic   proc_go;
  logic   in_take;

  dwpn_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dwpn_decide u_decide (
    .cfg          (cfg),
    .st           (st_r),
    .func         (q_func_r),
    .now_ms       (q_now_r),
    .press_len_ms (q_dur_r),
    .st_nxt       (st_nxt),
    .dec          (dec)
  );

  assign out_free = !out_vld_r || !out_stall;
  assign proc_go  = q_vld_r && out_free;
  assign in_stall = q_vld_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      st_r.page     <= PAGE_MAIN;
      st_r.settings <= 1'b0;
      st_r.screen   <= 1'b1;
      st_r.last_ms  <= '0;
    end else begin
      if (in_take) begin
        q_vld_r <= 1'b1;
      end else if (proc_go) begin
        q_vld_r <= 1'b0;
      end
      if (proc_go) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      q_func_r <= in_func;
      q_now_r  <= in_now_ms;
      q_dur_r  <= in_press_len_ms;
    end
    if (proc_go) begin
      dec_r <= dec;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_changed       = dec_r.changed;
  assign out_active_page   = dec_r.page;
  assign out_settings_open = dec_r.settings;
  assign out_screen_on     = dec_r.screen;
  assign out_wake_display  = dec_r.wake;
  assign out_blank_display = dec_r.blank;
  assign out_reset_idle    = dec_r.rst_idle;
  assign out_reason        = dec_r.reason;

`ifndef SYNTHESIS
  a_page_legal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.page != 2'd3)
    else $error("page register holds an illegal code");

  a_restart_state: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go && q_func_r == FUNC_RESTART |=>
      st_r.page == PAGE_MAIN && st_r.screen && !st_r.settings)
    else $error("restart did not return the state to its defaults");

  a_wake_blank_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(dec_r.wake && dec_r.blank))
    else $error("wake and blank pulses in the same beat");

  a_blank_screen_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && dec_r.blank |-> !dec_r.screen && !dec_r.settings)
    else $error("blank beat reports screen on or settings open");

  a_state_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go |=> dec_r.page == st_r.page && dec_r.screen == st_r.screen)
    else $error("result beat disagrees with the state register");
`endif

endmodule

@@ hdl/dwpn_cfg_regs.sv @@
// Configuration registers of the wake and navigation policy.
// Depends on dwpn_pkg.
module dwpn_cfg_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  dwpn_pkg::cfg_idx_t    cfg_index,
  input  logic [15:0]           cfg_wdata,
  output dwpn_pkg::cfg_t        cfg
);
  import dwpn_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDLE_TIMEOUT: cfg_nxt.idle_sec  = cfg_wdata[7:0];
        CFG_PRESS_MIN:    cfg_nxt.press_min = cfg_wdata;
        CFG_PRESS_MAX:    cfg_nxt.press_max = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_sec  <= IDLE_SEC_RST;
      cfg_r.press_min <= PRESS_MIN_RST;
      cfg_r.press_max <= PRESS_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/dwpn_decide.sv @@
// Combinational decision logic: next state and decision for one event.
// Depends on dwpn_pkg.
module dwpn_decide (
  input  dwpn_pkg::cfg_t   cfg,
  input  dwpn_pkg::state_t st,
  input  dwpn_pkg::func_t  func,
  input  dwpn_pkg::time_t  now_ms,
  input  dwpn_pkg::dur_t   press_len_ms,
  output dwpn_pkg::state_t st_nxt,
  output dwpn_pkg::dec_t   dec
);
  import dwpn_pkg::*;

  logic [LimW-1:0] lim;
  time_t           lim_ext;
  time_t           deadline;
  logic [TimeW:0]  now_sum;
  logic            behind;
  logic            expired;
  logic            short_glitch;
  logic            long_press;
  logic            swipe;

  assign lim      = timeout_ms(cfg.idle_sec);
  assign lim_ext  = {{(TimeW-LimW){1'b0}}, lim};
  assign deadline = st.last_ms + lim_ext;
  assign now_sum  = {1'b0, now_ms} + {1'b0, lim_ext};
  assign behind   = now_ms < st.last_ms;
  // When the anchor is pulled back to now, only a wrap of now + limit expires.
  assign expired  = behind ? now_sum[TimeW] : !(now_ms < deadline);

  assign short_glitch = press_len_ms <= {{(DurW-CfgW){1'b0}}, cfg.press_min};
  assign long_press   = press_len_ms >  {{(DurW-CfgW){1'b0}}, cfg.press_max};
  assign swipe = (func == FUNC_SW_LEFT) || (func == FUNC_SW_RIGHT) ||
                 (func == FUNC_SW_DOWN) || (func == FUNC_SW_UP);

  always_comb begin
    st_nxt       = st;
    dec.changed  = 1'b0;
    dec.wake     = 1'b0;
    dec.blank    = 1'b0;
    dec.rst_idle = 1'b0;
    dec.reason   = RSN_IGNORED;

    case (func)
      FUNC_ACTIVITY: begin
        st_nxt.last_ms = now_ms;
        dec.changed    = 1'b1;
        dec.rst_idle   = 1'b1;
        dec.reason     = RSN_ACTIVITY;
      end
      FUNC_IDLE_CHK: begin
        if (st.screen) begin
          if (behind) begin
            st_nxt.last_ms = now_ms;
          end
          if (expired) begin
            st_nxt.screen   = 1'b0;
            st_nxt.settings = 1'b0;
            dec.changed     = 1'b1;
            dec.blank       = 1'b1;
            dec.reason      = RSN_IDLE_OFF;
          end
        end
      end
      FUNC_TOUCH: begin
        if (!st.screen) begin
          st_nxt.screen  = 1'b1;
          st_nxt.last_ms = now_ms;
          dec.changed    = 1'b1;
          dec.wake       = 1'b1;
          dec.rst_idle   = 1'b1;
          dec.reason     = RSN_TOUCH_WAKE;
        end
      end
      FUNC_POWER: begin
        if (short_glitch) begin
          dec.reason = RSN_GLITCH;
        end else if (long_press) begin
          dec.reason = RSN_LONG;
        end else begin
          st_nxt.last_ms = now_ms;
          dec.changed    = 1'b1;
          dec.rst_idle   = 1'b1;
          if (!st.screen) begin
            st_nxt.screen = 1'b1;
            dec.wake      = 1'b1;
            dec.reason    = RSN_KEY_WAKE;
          end else if (st.settings) begin
            st_nxt.settings = 1'b0;
            dec.reason      = RSN_KEY_CLOSE;
          end else begin
            st_nxt.page = page_next(st.page);
            dec.reason  = RSN_KEY_PAGE;
          end
        end
      end
      FUNC_RESTART: begin
        st_nxt.page     = PAGE_MAIN;
        st_nxt.settings = 1'b0;
        st_nxt.screen   = 1'b1;
        st_nxt.last_ms  = now_ms;
        dec.changed     = 1'b1;
        dec.rst_idle    = 1'b1;
        dec.reason      = RSN_RESTARTED;
      end
      default: begin
        if (swipe) begin
          st_nxt.last_ms = now_ms;
          dec.changed    = 1'b1;
          dec.rst_idle   = 1'b1;
          if (!st.screen) begin
            st_nxt.screen = 1'b1;
            dec.wake      = 1'b1;
            dec.reason    = RSN_TOUCH_WAKE;
          end else if (func == FUNC_SW_DOWN) begin
            // Swipe down opens settings, or only restarts the timer if open.
            st_nxt.settings = 1'b1;
            dec.reason      = st.settings ? RSN_ACTIVITY : RSN_OPEN_SET;
          end else if (st.settings) begin
            st_nxt.settings = 1'b0;
            dec.reason      = RSN_CLOSE_SET;
          end else if (func == FUNC_SW_UP) begin
            dec.reason = RSN_ACTIVITY;
          end else begin
            st_nxt.page = (func == FUNC_SW_LEFT) ? page_next(st.page)
                                                 : page_prev(st.page);
            dec.reason  = RSN_SWIPE_PAGE;
          end
        end
      end
    endcase

    dec.page     = st_nxt.page;
    dec.settings = st_nxt.settings;
    dec.screen   = st_nxt.screen;
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for display_wake_and_page_nav_policy: directed and random UI
// events, with an in-bench prediction of each decision. Depends on dwpn_pkg and the RTL.
module tb;
  import dwpn_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int RxHoldCycles  = 80;

  typedef struct packed {
    func_t func;
    time_t now;
    dur_t  dur;
  } ui_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  func_t       in_func = FUNC_ACTIVITY;
  time_t       in_now_ms = '0;
  dur_t        in_press_len_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_changed;
  page_t       out_active_page;
  logic        out_settings_open;
  logic        out_screen_on;
  logic        out_wake_display;
  logic        out_blank_display;
  logic        out_reset_idle;
  reason_t     out_reason;
  logic        cfg_wr_en = 1'b0;
  cfg_idx_t    cfg_index = CFG_IDLE_TIMEOUT;
  logic [15:0] cfg_wdata = '0;

  display_wake_and_page_nav_policy DUT (.*);

  // Policy state and register copies used for prediction.
  page_t       m_page;
  logic        m_settings;
  logic        m_screen;
  time_t       m_last;
  logic [7:0]  m_idle_sec;
  logic [15:0] m_press_min;
  logic [15:0] m_press_max;

  ui_event_t   ui_q[$];
  dec_t        decision_q[$];
  ui_event_t   next_ev;
  int          offered_n = 0;
  int          taken_n = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          tx_idle_pct = 20;
  int          rx_idle_pct = 20;
  int          rx_hold_ask = 0;
  int          rx_hold_seen = 0;
  int          rx_hold_left = 0;
  logic        calm = 1'b0;
  time_t       t_clock;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic page_t turn_page(page_t p, logic fwd);
    case (p)
      PAGE_MAIN:  turn_page = fwd ? PAGE_TEXT : PAGE_STATS;
      PAGE_TEXT:  turn_page = fwd ? PAGE_STATS : PAGE_MAIN;
      PAGE_STATS: turn_page = fwd ? PAGE_MAIN : PAGE_TEXT;
      default:    turn_page = PAGE_MAIN;
    endcase
  endfunction

  // Updates the policy state for one event and returns the decision it yields.
  function automatic dec_t apply_policy(func_t f, time_t now, dur_t dur);
    dec_t  d;
    time_t lim;
    d = '0;
    d.reason = RSN_IGNORED;
    case (m_idle_sec)
      8'd5:    lim = 64'd5000;
      8'd30:   lim = 64'd30000;
      default: lim = 64'd15000;
    endcase
    case (f)
      FUNC_ACTIVITY: begin
        m_last = now;
        d.changed = 1'b1;
        d.rst_idle = 1'b1;
        d.reason = RSN_ACTIVITY;
      end
      FUNC_IDLE_CHK: begin
        if (m_screen) begin
          if (now < m_last) m_last = now;
          // The limit sum wraps at 64 bits.
          if (now >= m_last + lim) begin
            m_screen = 1'b0;
            m_settings = 1'b0;
            d.changed = 1'b1;
            d.blank = 1'b1;
            d.reason = RSN_IDLE_OFF;
          end
        end
      end
      FUNC_TOUCH: begin
        if (!m_screen) begin
          m_screen = 1'b1;
          m_last = now;
          d.changed = 1'b1;
          d.wake = 1'b1;
          d.rst_idle = 1'b1;
          d.reason = RSN_TOUCH_WAKE;
        end
      end
      FUNC_POWER: begin
        if (dur <= dur_t'(m_press_min)) begin
          d.reason = RSN_GLITCH;
        end else if (dur > dur_t'(m_press_max)) begin
          d.reason = RSN_LONG;
        end else begin
          m_last = now;
          d.changed = 1'b1;
          d.rst_idle = 1'b1;
          if (!m_screen) begin
            m_screen = 1'b1;
            d.wake = 1'b1;
            d.reason = RSN_KEY_WAKE;
          end else if (m_settings) begin
            m_settings = 1'b0;
            d.reason = RSN_KEY_CLOSE;
          end else begin
            m_page = turn_page(m_page, 1'b1);
            d.reason = RSN_KEY_PAGE;
          end
        end
      end
      FUNC_SW_LEFT, FUNC_SW_RIGHT, FUNC_SW_DOWN, FUNC_SW_UP: begin
        m_last = now;
        d.changed = 1'b1;
        d.rst_idle = 1'b1;
        if (!m_screen) begin
          m_screen = 1'b1;
          d.wake = 1'b1;
          d.reason = RSN_TOUCH_WAKE;
        end else if (f == FUNC_SW_DOWN) begin
          if (!m_settings) begin
            m_settings = 1'b1;
            d.reason = RSN_OPEN_SET;
          end else begin
            d.reason = RSN_ACTIVITY;
          end
        end else if (m_settings) begin
          m_settings = 1'b0;
          d.reason = RSN_CLOSE_SET;
        end else if (f == FUNC_SW_UP) begin
          d.reason = RSN_ACTIVITY;
        end else begin
          m_page = turn_page(m_page, f == FUNC_SW_LEFT);
          d.reason = RSN_SWIPE_PAGE;
        end
      end
      FUNC_RESTART: begin
        m_page = PAGE_MAIN;
        m_settings = 1'b0;
        m_screen = 1'b1;
        m_last = now;
        d.changed = 1'b1;
        d.rst_idle = 1'b1;
        d.reason = RSN_RESTARTED;
      end
      default: ;
    endcase
    d.page = m_page;
    d.settings = m_settings;
    d.screen = m_screen;
    return d;
  endfunction

  // Sender: one beat per event from the pending queue, with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && taken_n != offered_n) begin
      // Stalled beat stays on the bus unchanged.
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap = tx_gap - 1;
    end else if (ui_q.size() != 0) begin
      if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        tx_gap = $urandom_range(1, 10) - 1;
      end else begin
        next_ev = ui_q.pop_front();
        in_func <= next_ev.func;
        in_now_ms <= next_ev.now;
        in_press_len_ms <= next_ev.dur;
        in_valid <= 1'b1;
        offered_n = offered_n + 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rx_hold_ask != rx_hold_seen) begin
      rx_hold_seen = rx_hold_ask;
      rx_hold_left = RxHoldCycles;
    end
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left = rx_hold_left - 1;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap = rx_gap - 1;
    end else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
      out_stall <= 1'b1;
      rx_gap = $urandom_range(1, 10) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predicts on accepted input beats, checks accepted result beats.
  always @(posedge clk) begin
    dec_t got;
    dec_t want;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decision_q.push_back(apply_policy(in_func, in_now_ms, in_press_len_ms));
        taken_n = taken_n + 1;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got.changed = out_changed;
        got.page = out_active_page;
        got.settings = out_settings_open;
        got.screen = out_screen_on;
        got.wake = out_wake_display;
        got.blank = out_blank_display;
        got.rst_idle = out_reset_idle;
        got.reason = out_reason;
        if (decision_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: decision beat with nothing expected", $realtime);
        end else begin
          want = decision_q.pop_front();
          if (got.changed !== want.changed || got.page !== want.page ||
              got.settings !== want.settings || got.screen !== want.screen ||
              got.wake !== want.wake || got.blank !== want.blank ||
              got.rst_idle !== want.rst_idle || got.reason !== want.reason) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display({"%0t: mismatch exp chg=%0d pg=%0d set=%0d scr=%0d wake=%0d ",
                        "blank=%0d rst=%0d rsn=%0d / got chg=%0d pg=%0d set=%0d scr=%0d ",
                        "wake=%0d blank=%0d rst=%0d rsn=%0d"}, $realtime,
                       want.changed, want.page, want.settings, want.screen, want.wake,
                       want.blank, want.rst_idle, want.reason, got.changed, got.page,
                       got.settings, got.screen, got.wake, got.blank, got.rst_idle,
                       got.reason);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no beat moved for %0d cycles", $realtime, WatchdogLimit);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  task automatic push_ev(func_t f, time_t now, dur_t dur);
    ui_event_t ev;
    ev.func = f;
    ev.now = now;
    ev.dur = dur;
    ui_q.push_back(ev);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_IDLE_TIMEOUT: m_idle_sec = val[7:0];
      CFG_PRESS_MIN:    m_press_min = val;
      CFG_PRESS_MAX:    m_press_max = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure(logic [7:0] sec, logic [15:0] pmin, logic [15:0] pmax);
    write_reg(CFG_IDLE_TIMEOUT, {8'd0, sec});
    write_reg(CFG_PRESS_MIN, pmin);
    write_reg(CFG_PRESS_MAX, pmax);
  endtask

  // Waits until every event has been taken and every decision has come back.
  task automatic drain();
    while (ui_q.size() != 0 || taken_n != offered_n || decision_q.size() != 0 || in_valid)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_events(int count);
    func_t f;
    time_t now;
    dur_t  dur;
    int    r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8)       f = FUNC_ACTIVITY;
      else if (r < 22) f = FUNC_IDLE_CHK;
      else if (r < 30) f = FUNC_TOUCH;
      else if (r < 55) f = FUNC_POWER;
      else if (r < 63) f = FUNC_SW_LEFT;
      else if (r < 71) f = FUNC_SW_RIGHT;
      else if (r < 81) f = FUNC_SW_DOWN;
      else if (r < 89) f = FUNC_SW_UP;
      else if (r < 92) f = FUNC_RESTART;
      else             f = func_t'($urandom_range(9, 15));
      // Mostly a forward-moving clock; now and then a step back or a wild stamp.
      r = $urandom_range(0, 99);
      if (r < 55) begin
        t_clock = t_clock + $urandom_range(0, 3000);
        now = t_clock;
      end else if (r < 85) begin
        t_clock = t_clock + $urandom_range(3000, 35000);
        now = t_clock;
      end else if (r < 93) begin
        now = t_clock - $urandom_range(0, 6000);
      end else begin
        now = {$urandom, $urandom};
      end
      r = $urandom_range(0, 9);
      if (f != FUNC_POWER || r == 0) dur = $urandom;
      else if (r < 3) dur = dur_t'(m_press_min) + $urandom_range(0, 2);
      else if (r < 5) dur = dur_t'(m_press_max) + $urandom_range(0, 2);
      else if (r < 6) dur = $urandom_range(0, 2000);
      else if (m_press_min < m_press_max)
        dur = $urandom_range(int'(m_press_max), int'(m_press_min) + 1);
      else dur = $urandom_range(0, 70000);
      push_ev(f, now, dur);
    end
  endtask

  initial begin
    m_page = PAGE_MAIN;
    m_settings = 1'b0;
    m_screen = 1'b1;
    m_last = '0;
    m_idle_sec = IDLE_SEC_RST;
    m_press_min = PRESS_MIN_RST;
    m_press_max = PRESS_MAX_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed events at the register defaults.
    push_ev(FUNC_RESTART,  64'd1000, 32'd0);
    push_ev(FUNC_ACTIVITY, 64'd0, 32'hFFFF_FFFF);
    push_ev(FUNC_IDLE_CHK, 64'd14999, 32'd0);
    push_ev(FUNC_IDLE_CHK, 64'd15000, 32'd0);
    push_ev(FUNC_IDLE_CHK, 64'd99999, 32'd0);      // screen already off
    push_ev(FUNC_SW_LEFT,  64'd100000, 32'd0);     // swipe only wakes
    push_ev(FUNC_TOUCH,    64'd100010, 32'd0);     // screen on, ignored
    push_ev(FUNC_SW_DOWN,  64'd100020, 32'd0);
    push_ev(FUNC_SW_DOWN,  64'd100030, 32'd0);     // settings open: idle restart only
    push_ev(FUNC_POWER,    64'd100040, 32'd0);
    push_ev(FUNC_POWER,    64'd100050, 32'd50);
    push_ev(FUNC_POWER,    64'd100060, 32'd51);    // closes settings
    push_ev(FUNC_POWER,    64'd100070, 32'd1000);
    push_ev(FUNC_POWER,    64'd100080, 32'd1001);
    push_ev(FUNC_POWER,    64'd100090, 32'hFFFF_FFFF);
    push_ev(FUNC_SW_LEFT,  64'd100100, 32'd0);
    push_ev(FUNC_SW_LEFT,  64'd100110, 32'd0);
    push_ev(FUNC_SW_RIGHT, 64'd100120, 32'd0);
    push_ev(FUNC_SW_UP,    64'd100130, 32'd0);
    push_ev(FUNC_SW_DOWN,  64'd100140, 32'd0);
    push_ev(FUNC_SW_UP,    64'd100150, 32'd0);
    push_ev(FUNC_IDLE_CHK, 64'd50, 32'd0);         // behind the anchor
    push_ev(FUNC_IDLE_CHK, 64'd15049, 32'd0);
    push_ev(FUNC_ACTIVITY, 64'hFFFF_FFFF_FFFF_F000, 32'd0);
    push_ev(FUNC_IDLE_CHK, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);  // limit sum wraps
    push_ev(FUNC_TOUCH,    64'd5, 32'd0);
    push_ev(FUNC_IDLE_CHK, 64'd20000, 32'd0);
    push_ev(FUNC_POWER,    64'd20010, 32'd500);    // key wake
    push_ev(func_t'(9),    64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    push_ev(func_t'(15),   64'd0, 32'd0);
    push_ev(FUNC_RESTART,  64'hAAAA_5555_AAAA_5555, 32'd0);
    drain();

    t_clock = 64'd1000;
    configure(8'd5, 16'd0, 16'd65535);
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    random_events(140);
    // Long receiver hold-off while the sender keeps offering beats.
    rx_hold_ask = rx_hold_ask + 1;
    drain();

    configure(8'd30, 16'd65535, 16'd65535);
    t_clock = 64'hFFFF_FFFF_FFFF_0000;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_events(140);
    drain();

    configure(8'd255, 16'd200, 16'd50);
    tx_idle_pct = 15;
    rx_idle_pct = 40;
    random_events(140);
    drain();

    configure(8'd0, 16'd20, 16'd3000);
    tx_idle_pct = 40;
    rx_idle_pct = 10;
    random_events(140);
    drain();

    configure(8'd15, 16'd50, 16'd1000);
    calm = 1'b1;
    random_events(150);
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0 && decision_q.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
